@@ sv/efd_pkg.sv @@
// Shared types and constants for the escaped frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package efd_pkg;

    localparam int MAX_LEN = 64;
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int DATA_W = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);
    localparam logic [LEN_W-1:0] MIN_FRAME = LEN_W'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_NEWLINE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK = 2'd2;

    localparam logic [DATA_W-1:0] RST_NEWLINE = 8'd10;
    localparam logic [DATA_W-1:0] RST_ESCAPE = 8'd27;
    localparam logic [DATA_W-1:0] RST_MASK = 8'd128;

    typedef enum logic
    {
        CMD_STORE,
        CMD_END
    } cmd_kind_t;

    typedef struct packed
    {
        cmd_kind_t kind;
        logic [DATA_W-1:0] data;
    } cmd_t;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_READ,
        BK_SHOW
    } back_state_t;

endpackage

`default_nettype wire

@@ sv/efd_front.sv @@
// Front end: configuration registers, escape tracking and byte classification.
`timescale 1ns / 1ps
`default_nettype none

module efd_front
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [efd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [efd_pkg::DATA_W-1:0]     cfg_data,
    input  wire logic                           rx_valid,
    output logic                                rx_stall,
    input  wire logic [efd_pkg::DATA_W-1:0]     rx_byte,
    input  wire logic                           q_full,
    output logic                                push,
    output efd_pkg::cmd_t                       push_cmd
);
    import efd_pkg::*;

    logic [DATA_W-1:0] newline_reg;
    logic [DATA_W-1:0] escape_reg;
    logic [DATA_W-1:0] mask_reg;
    logic              pend_reg;
    logic              pend_next;
    logic              accept;

    assign cfg_ready = 1'b1;
    assign rx_stall = q_full;
    assign accept = rx_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newline_reg <= RST_NEWLINE;
            escape_reg <= RST_ESCAPE;
            mask_reg <= RST_MASK;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NEWLINE: newline_reg <= cfg_data;
                CFG_ESCAPE:  escape_reg <= cfg_data;
                CFG_MASK:    mask_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // The newline test comes first, so a newline never touches the escape flag.
    always_comb
    begin
        pend_next = pend_reg;
        push = 1'b0;
        push_cmd.kind = CMD_STORE;
        push_cmd.data = rx_byte;
        if (accept)
        begin
            if (rx_byte == newline_reg)
            begin
                push = 1'b1;
                push_cmd.kind = CMD_END;
            end
            else if (!pend_reg && rx_byte == escape_reg)
            begin
                pend_next = 1'b1;
            end
            else if (pend_reg)
            begin
                push = 1'b1;
                push_cmd.data = rx_byte & ~mask_reg;
                pend_next = 1'b0;
            end
            else
            begin
                push = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/efd_queue.sv @@
// Two-entry command queue between the front end and the frame engine.
`timescale 1ns / 1ps
`default_nettype none

module efd_queue
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire efd_pkg::cmd_t push_cmd,
    output logic               full,
    output logic               q_valid,
    output efd_pkg::cmd_t      q_cmd,
    input  wire logic          pop
);
    import efd_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full = count_reg == 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign q_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/efd_back.sv @@
// Frame engine: collects bytes in the frame memory and drains finished frames.
`timescale 1ns / 1ps
`default_nettype none

module efd_back
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_valid,
    input  wire efd_pkg::cmd_t               q_cmd,
    output logic                             pop,
    output logic                             frame_valid,
    input  wire logic                        frame_stall,
    output logic [efd_pkg::DATA_W-1:0]       frame_byte,
    output logic                             frame_last
);
    import efd_pkg::*;

    logic [DATA_W-1:0] mem [MAX_LEN];
    logic [DATA_W-1:0] rd_data_reg;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [LEN_W-1:0]  drain_len_reg;
    logic [LEN_W-1:0]  drain_len_next;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;

    logic              wr_en;
    logic              rd_en;
    logic              is_last;
    logic              start_drain;

    assign is_last = (LEN_W'(idx_reg) + LEN_W'(1)) == drain_len_reg;
    assign start_drain = q_valid && q_cmd.kind == CMD_END && len_reg >= MIN_FRAME;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (start_drain)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                state_next = BK_SHOW;
            end
            BK_SHOW:
            begin
                if (!frame_stall)
                begin
                    state_next = is_last ? BK_IDLE : BK_READ;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop = 1'b0;
        wr_en = 1'b0;
        rd_en = 1'b0;
        frame_valid = 1'b0;
        len_next = len_reg;
        drain_len_next = drain_len_reg;
        idx_next = idx_reg;
        case (state_reg)
            BK_IDLE:
            begin
                pop = q_valid;
                if (q_valid)
                begin
                    if (q_cmd.kind == CMD_END)
                    begin
                        len_next = '0;
                        drain_len_next = len_reg;
                        idx_next = '0;
                    end
                    else if (len_reg >= LEN_MAX)
                    begin
                        // Overlong frame: the byte is lost and the frame restarts empty.
                        len_next = '0;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        len_next = len_reg + LEN_W'(1);
                    end
                end
            end
            BK_READ:
            begin
                rd_en = 1'b1;
            end
            BK_SHOW:
            begin
                frame_valid = 1'b1;
                if (!frame_stall)
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[len_reg[ADDR_W-1:0]] <= q_cmd.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            len_reg <= '0;
            drain_len_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg <= len_next;
            drain_len_reg <= drain_len_next;
            idx_reg <= idx_next;
        end
    end

    assign frame_byte = rd_data_reg;
    assign frame_last = is_last;

endmodule

`default_nettype wire

@@ sv/escaped_frame_decoder.sv @@
// Top level of the escaped frame decoder: front end, command queue and frame engine.
//
//   channel  direction  handshake            payload
//   rx       in         rx_valid/rx_stall    rx_byte
//   frame    out        frame_valid/stall    frame_byte, frame_last
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The front end takes one rx request per cycle while the two-entry queue has room.
// The frame engine retires one queued byte per cycle while idle; a finished frame is
// drained byte by byte (memory read, then presentation, held while frame_stall is high).
// While a frame drains, the queue fills and rx_stall rises until the drain ends.
// Reset clears flags and counts and loads the reset configuration; frame memory is kept.
`timescale 1ns / 1ps
`default_nettype none

module escaped_frame_decoder
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [efd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [efd_pkg::DATA_W-1:0]     cfg_data,
    input  wire logic                           rx_valid,
    output logic                                rx_stall,
    input  wire logic [efd_pkg::DATA_W-1:0]     rx_byte,
    output logic                                frame_valid,
    input  wire logic                           frame_stall,
    output logic [efd_pkg::DATA_W-1:0]          frame_byte,
    output logic                                frame_last
);
    import efd_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic q_valid;
    cmd_t q_cmd;
    logic pop;

    efd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_byte   (rx_byte),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    efd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop)
    );

    efd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .pop         (pop),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_byte  (frame_byte),
        .frame_last  (frame_last)
    );

endmodule

`default_nettype wire

@@ verif/tb_escaped_frame_decoder.sv @@
// Self-checking testbench for the escaped frame decoder: directed table, then random frames.
`timescale 1ns / 1ps
`default_nettype none

module tb_escaped_frame_decoder;

    import efd_pkg::*;

    localparam int SETTLE_CYCLES = 2 * MAX_LEN + 16;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int IDLE_PERCENT = 38;
    localparam int PHASES = 5;
    localparam int PHASE_ITEMS = 54;
    localparam int DIR_ROWS = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed
    {
        logic [DATA_W-1:0] data;
        logic last;
    } frame_beat_t;

    typedef enum logic [1:0]
    {
        ROW_PREDICTED,
        ROW_NO_FRAME,
        ROW_PAIR
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t kind;
        logic [DATA_W-1:0] rx;
        logic [DATA_W-1:0] first;
        logic [DATA_W-1:0] second;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;
    logic rx_valid = 1'b0;
    logic rx_stall;
    logic [DATA_W-1:0] rx_byte = '0;
    logic frame_valid;
    logic frame_stall = 1'b0;
    logic [DATA_W-1:0] frame_byte;
    logic frame_last;

    // Decoder image kept by the testbench.
    logic [DATA_W-1:0] newline_val = RST_NEWLINE;
    logic [DATA_W-1:0] escape_val = RST_ESCAPE;
    logic [DATA_W-1:0] mask_val = RST_MASK;
    logic [DATA_W-1:0] collected [MAX_LEN];
    int unsigned collected_len = 0;
    bit escape_armed = 1'b0;

    frame_beat_t decoded_beats [$];
    frame_beat_t awaited_beats [$];
    dir_row_t directed_rows [DIR_ROWS];

    int errors = 0;
    int items_sent = 0;
    int silent_cycles = 0;
    int hold_left = 0;
    bit no_gaps = 1'b0;
    bit hold_off_req = 1'b0;
    logic [DATA_W-1:0] shared_code;

    escaped_frame_decoder dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .rx_byte     (rx_byte),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_byte  (frame_byte),
        .frame_last  (frame_last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Advances the decoder image by one received byte; any finished frame lands in
    // decoded_beats.
    function automatic void decode_byte(input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] stored;
        frame_beat_t beat;
        stored = b;
        decoded_beats.delete();
        if (b == newline_val)
        begin
            if (collected_len >= MIN_FRAME)
            begin
                for (int i = 0; i < collected_len; i++)
                begin
                    beat.data = collected[i];
                    beat.last = (i == collected_len - 1);
                    decoded_beats.insert(decoded_beats.size(), beat);
                end
            end
            collected_len = 0;
        end
        else if (!escape_armed && b == escape_val)
        begin
            escape_armed = 1'b1;
        end
        else
        begin
            if (escape_armed)
                stored = b & ~mask_val;
            escape_armed = 1'b0;
            // A byte arriving on a full buffer throws the whole frame away.
            if (collected_len >= MAX_LEN)
                collected_len = 0;
            else
            begin
                collected[collected_len] = stored;
                collected_len++;
            end
        end
    endfunction

    function automatic bit take_break();
        return !no_gaps && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    function automatic int pick_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return $urandom_range(1, 0);
        if (roll < 12)
            return $urandom_range(MAX_LEN + 2, MAX_LEN - 1);
        return $urandom_range(16, 2);
    endfunction

    task automatic send_raw(input logic [DATA_W-1:0] b);
        while (take_break())
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (rx_stall);
        items_sent++;
    endtask

    task automatic send_byte(input logic [DATA_W-1:0] b);
        send_raw(b);
        decode_byte(b);
        foreach (decoded_beats[i])
            awaited_beats.insert(awaited_beats.size(), decoded_beats[i]);
    endtask

    // Sends len stored bytes and a terminator. Bytes equal to the terminator are nudged
    // away; bytes equal to the escape are stuffed. Unless clean, a few stray
    // terminators and escapes break frames up.
    task automatic send_frame(input int len, input bit clean);
        logic [DATA_W-1:0] d;
        int roll;
        for (int k = 0; k < len; k++)
        begin
            roll = $urandom_range(99);
            d = DATA_W'($urandom_range(255));
            if (d == newline_val)
                d = d ^ 8'h01;
            if (!clean && roll < 4)
                send_byte(roll[0] ? newline_val : escape_val);
            else if (roll < 20 && escape_val != newline_val)
            begin
                send_byte(escape_val);
                send_byte(d);
            end
            else
            begin
                if (d == escape_val)
                    send_byte(escape_val);
                send_byte(d);
            end
        end
        send_byte(newline_val);
    endtask

    task automatic wait_idle();
        rx_valid <= 1'b0;
        while (awaited_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the unused index as well; the block must ignore it.
    task automatic program_regs(input logic [DATA_W-1:0] nl, esc, msk);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [DATA_W-1:0] val [4];
        idx = '{CFG_UNUSED, CFG_NEWLINE, CFG_ESCAPE, CFG_MASK};
        val = '{DATA_W'($urandom_range(255)), nl, esc, msk};
        for (int k = 0; k < 4; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= val[k];
            do @(posedge clk); while (!cfg_ready);
            case (idx[k])
                CFG_NEWLINE: newline_val = val[k];
                CFG_ESCAPE: escape_val = val[k];
                CFG_MASK: mask_val = val[k];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin : receive_side
        frame_beat_t want;
        if (rst_n && frame_valid && !frame_stall)
        begin
            if (awaited_beats.size() == 0)
            begin
                $error("unexpected frame request: frame_byte %02h frame_last %0b",
                       frame_byte, frame_last);
                errors++;
            end
            else
            begin
                want = awaited_beats.pop_front();
                if (frame_byte !== want.data)
                begin
                    $error("frame_byte mismatch: expected %02h, actual %02h",
                           want.data, frame_byte);
                    errors++;
                end
                if (frame_last !== want.last)
                begin
                    $error("frame_last mismatch: expected %0b, actual %0b",
                           want.last, frame_last);
                    errors++;
                end
            end
        end
        if (hold_off_req)
        begin
            hold_left = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            frame_stall <= 1'b1;
        end
        else
            frame_stall <= take_break();
    end

    always @(posedge clk)
    begin
        if (!rst_n || (rx_valid && !rx_stall) || (frame_valid && !frame_stall)
            || (cfg_valid && cfg_ready))
            silent_cycles = 0;
        else
            silent_cycles++;
        if (silent_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        // Rows for the reset settings; pair rows carry their frame, no-frame rows expect none.
        directed_rows = '{
            '{ROW_NO_FRAME,  RST_NEWLINE, 8'h00, 8'h00},
            '{ROW_PREDICTED, 8'h41,       8'h00, 8'h00},
            '{ROW_NO_FRAME,  RST_NEWLINE, 8'h00, 8'h00},
            '{ROW_PREDICTED, 8'h00,       8'h00, 8'h00},
            '{ROW_PREDICTED, 8'hFF,       8'h00, 8'h00},
            '{ROW_PAIR,      RST_NEWLINE, 8'h00, 8'hFF},
            '{ROW_PREDICTED, RST_ESCAPE,  8'h00, 8'h00},
            '{ROW_PREDICTED, 8'hFF,       8'h00, 8'h00},
            '{ROW_PREDICTED, RST_ESCAPE,  8'h00, 8'h00},
            '{ROW_PREDICTED, 8'h80,       8'h00, 8'h00},
            '{ROW_PAIR,      RST_NEWLINE, 8'h7F, 8'h00},
            '{ROW_PREDICTED, RST_ESCAPE,  8'h00, 8'h00},
            '{ROW_PREDICTED, RST_ESCAPE,  8'h00, 8'h00},
            '{ROW_PREDICTED, 8'h55,       8'h00, 8'h00},
            '{ROW_PAIR,      RST_NEWLINE, RST_ESCAPE, 8'h55},
            '{ROW_PREDICTED, RST_ESCAPE,  8'h00, 8'h00},
            '{ROW_NO_FRAME,  RST_NEWLINE, 8'h00, 8'h00},
            '{ROW_PREDICTED, 8'hC1,       8'h00, 8'h00},
            '{ROW_PREDICTED, 8'h42,       8'h00, 8'h00},
            '{ROW_PAIR,      RST_NEWLINE, 8'h41, 8'h42}
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            send_raw(directed_rows[r].rx);
            decode_byte(directed_rows[r].rx);
            case (directed_rows[r].kind)
                ROW_PREDICTED:
                    foreach (decoded_beats[i])
                        awaited_beats.insert(awaited_beats.size(), decoded_beats[i]);
                ROW_PAIR:
                begin
                    awaited_beats.insert(awaited_beats.size(),
                                         frame_beat_t'({directed_rows[r].first, 1'b0}));
                    awaited_beats.insert(awaited_beats.size(),
                                         frame_beat_t'({directed_rows[r].second, 1'b1}));
                end
                default: ;
            endcase
        end

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
            begin
                // A full buffer is still a frame; one byte more loses it. Neither side
                // pauses here.
                no_gaps = 1'b1;
                send_frame(MAX_LEN, 1'b1);
                send_frame(MAX_LEN + 1, 1'b1);
                no_gaps = 1'b0;
            end
            else
            begin
                wait_idle();
                shared_code = DATA_W'($urandom_range(255));
                case (p)
                    1: program_regs(8'h00, 8'hFF, 8'hFF);
                    2: program_regs(shared_code, shared_code, DATA_W'($urandom_range(255)));
                    3: program_regs(8'hFF, 8'h00, 8'h00);
                    default: program_regs(DATA_W'($urandom_range(255)),
                                          DATA_W'($urandom_range(255)),
                                          DATA_W'($urandom_range(255)));
                endcase
            end
            // The receiver stops taking requests for a while so the block backs up.
            hold_off_req = (p == 1);
            items_sent = 0;
            while (items_sent < PHASE_ITEMS)
                send_frame(pick_length(), 1'b0);
        end

        wait_idle();
        if (errors == 0 && awaited_beats.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
